>>> rtl/keccak_f1600_permutation_core_defines.svh
// Assertion helpers used by the core module to check itself.
`ifndef KECCAK_F1600_PERMUTATION_CORE_DEFINES_SVH
`define KECCAK_F1600_PERMUTATION_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KFP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/kfp_pkg.sv
package kfp_pkg;

    localparam int LANE_W      = 64;
    localparam int LANE_COUNT  = 25;
    localparam int LANE_IDX_W  = 5;
    localparam int LFSR_W      = 8;

    localparam logic [LANE_IDX_W-1:0] LANE_LAST  = 5'd24;
    localparam logic [LANE_IDX_W-1:0] ROUND_LAST = 5'd23;
    localparam logic [LFSR_W-1:0]     LFSR_SEED     = 8'h01;
    localparam logic [LFSR_W-1:0]     LFSR_FEEDBACK = 8'h71;

    // Rotation offset of each lane, indexed x+5*y
    localparam int RHO_OFFSET [LANE_COUNT] = '{
         0,  1, 62, 28, 27,
        36, 44,  6, 55, 20,
         3, 10, 43, 25, 39,
        41, 45, 15, 21,  8,
        18,  2, 61, 56, 14
    };

    typedef logic [LANE_W-1:0] t_lane;
    typedef logic [LANE_COUNT-1:0][LANE_W-1:0] t_state;

    typedef struct packed {
        t_lane lane;
        logic  last;
    } t_lane_word;

    typedef struct packed {
        t_lane             rc;
        logic [LFSR_W-1:0] lfsr;
    } t_iota;

    function automatic t_lane rotl(input t_lane v, input int n);
        return (v << n) | (v >> (LANE_W - n));
    endfunction

    // Seven LFSR steps give the round constant and the next seed.
    function automatic t_iota iota_step(input logic [LFSR_W-1:0] lfsr);
        t_iota             res;
        logic [LFSR_W-1:0] s;
        res.rc = '0;
        s      = lfsr;
        for (int k = 0; k < 7; k++) begin
            if (s[0]) begin
                res.rc[(1 << k) - 1] = 1'b1;
            end
            if (s[LFSR_W-1]) begin
                s = {s[LFSR_W-2:0], 1'b0} ^ LFSR_FEEDBACK;
            end else begin
                s = {s[LFSR_W-2:0], 1'b0};
            end
        end
        res.lfsr = s;
        return res;
    endfunction

    // One full round: theta, rho, pi, chi, iota.
    function automatic t_state keccak_round(input t_state a, input t_lane rc);
        t_lane  c [5];
        t_lane  d [5];
        t_lane  t;
        t_state b;
        t_state r;
        for (int x = 0; x < 5; x++) begin
            c[x] = a[x] ^ a[x+5] ^ a[x+10] ^ a[x+15] ^ a[x+20];
        end
        for (int x = 0; x < 5; x++) begin
            d[x] = c[(x+4)%5] ^ rotl(c[(x+1)%5], 1);
        end
        for (int x = 0; x < 5; x++) begin
            for (int y = 0; y < 5; y++) begin
                t = a[x+5*y] ^ d[x];
                b[y+5*((2*x+3*y)%5)] = rotl(t, RHO_OFFSET[x+5*y]);
            end
        end
        for (int y = 0; y < 5; y++) begin
            for (int x = 0; x < 5; x++) begin
                r[x+5*y] = b[x+5*y] ^ (~b[(x+1)%5+5*y] & b[(x+2)%5+5*y]);
            end
        end
        r[0] = r[0] ^ rc;
        return r;
    endfunction

endpackage

>>> rtl/kfp_front.sv
module kfp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  kfp_pkg::t_lane     i_lane_in,
    input  logic               i_q_full,
    output logic               o_q_push,
    output kfp_pkg::t_lane_word o_q_word
);
    import kfp_pkg::*;

    logic [LANE_IDX_W-1:0] r_lane_cnt;
    logic [LANE_IDX_W-1:0] n_lane_cnt;
    logic                  w_last;

    assign w_last   = (r_lane_cnt >= LANE_LAST);
    assign o_q_push = i_push && !i_q_full;
    assign o_q_word = '{lane: i_lane_in, last: w_last};

    // Advance the lane position; wrap after the last lane of a state
    always_comb begin
        n_lane_cnt = r_lane_cnt;
        if (o_q_push) begin
            n_lane_cnt = w_last ? '0 : r_lane_cnt + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_cnt <= '0;
        end else begin
            r_lane_cnt <= n_lane_cnt;
        end
    end

endmodule

>>> rtl/kfp_queue.sv
module kfp_queue #(
    parameter int DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  kfp_pkg::t_lane_word i_word,
    input  logic                i_pop,
    output kfp_pkg::t_lane_word o_word,
    output logic                o_full,
    output logic                o_empty
);
    import kfp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_lane_word       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_word    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

>>> rtl/kfp_back.sv
module kfp_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  kfp_pkg::t_lane_word    i_q_word,
    input  logic                   i_q_empty,
    output logic                   o_q_pop,
    input  logic                   i_pop,
    output logic                   o_empty,
    output kfp_pkg::t_lane         o_lane_out,
    output logic [4:0]             o_lane_number,
    output logic                   o_final_lane
);
    import kfp_pkg::*;

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_ROUND = 3'b010,
        ST_EMIT  = 3'b100
    } t_state_e;

    t_state_e              r_st;
    t_state_e              n_st;
    t_state                r_lanes;
    logic [LANE_IDX_W-1:0] r_round;
    logic [LFSR_W-1:0]     r_lfsr;
    logic [LANE_IDX_W-1:0] r_emit;
    logic                  r_out_valid;
    t_lane                 r_out_lane;
    logic [LANE_IDX_W-1:0] r_out_num;
    logic                  r_out_last;
    t_iota                 w_iota;
    logic                  w_out_free;
    logic                  w_emit;
    logic                  w_shift;

    assign w_iota     = iota_step(r_lfsr);
    assign w_out_free = !r_out_valid || i_pop;
    assign o_q_pop    = (r_st == ST_LOAD) && !i_q_empty;
    assign w_emit     = (r_st == ST_EMIT) && w_out_free;
    assign w_shift    = o_q_pop || w_emit;

    assign o_empty       = !r_out_valid;
    assign o_lane_out    = r_out_lane;
    assign o_lane_number = r_out_num;
    assign o_final_lane  = r_out_last;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_LOAD:  if (o_q_pop && i_q_word.last) n_st = ST_ROUND;
            ST_ROUND: if (r_round == ROUND_LAST) n_st = ST_EMIT;
            ST_EMIT:  if (w_emit && r_emit == LANE_LAST) n_st = ST_LOAD;
            default:  n_st = ST_LOAD;
        endcase
    end

    // Lane store: apply a round while permuting, shift in at the top while loading, out at the bottom while emitting
    always_ff @(posedge i_clk) begin
        if (r_st == ST_ROUND) begin
            r_lanes <= keccak_round(r_lanes, w_iota.rc);
        end else if (w_shift) begin
            for (int i = 0; i < LANE_COUNT - 1; i++) begin
                r_lanes[i] <= r_lanes[i+1];
            end
            r_lanes[LANE_COUNT-1] <= i_q_word.lane;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_lane <= r_lanes[0];
            r_out_num  <= r_emit;
            r_out_last <= (r_emit == LANE_LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_LOAD;
            r_round     <= '0;
            r_lfsr      <= LFSR_SEED;
            r_emit      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == ST_ROUND) begin
                if (r_round == ROUND_LAST) begin
                    r_round <= '0;
                    r_lfsr  <= LFSR_SEED;
                end else begin
                    r_round <= r_round + 5'd1;
                    r_lfsr  <= w_iota.lfsr;
                end
            end
            if (w_emit) begin
                r_emit <= (r_emit == LANE_LAST) ? '0 : r_emit + 5'd1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/keccak_f1600_permutation_core.sv
// Channel   | Handshake                | Word
// ----------+--------------------------+---------------------------------------------
// lane in   | push / full              | i_lane_in (64b), lanes in order x+5*y
// lane out  | empty / pop              | o_lane_out (64b), o_lane_number (5b),
//           |                          | o_final_lane (1b)
//
// A state is loaded one word a cycle from the queue while the queue is not empty, then
// permuted one full round a cycle and emitted; the single lane store loads, permutes and
// emits in turn, so a new state loads only after the last lane of the one before has left.
// Synchronous active-low reset clears counters, LFSR and output valid, not the lane store.
// While the back permutes or emits, the front fills the queue (QUEUE_DEPTH words) and then
// raises full; a stalled pop holds the back in emit with the result word held.
`include "keccak_f1600_permutation_core_defines.svh"

module keccak_f1600_permutation_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  kfp_pkg::t_lane i_lane_in,
    output logic           empty,
    input  logic           pop,
    output kfp_pkg::t_lane o_lane_out,
    output logic [4:0]     o_lane_number,
    output logic           o_final_lane
);
    import kfp_pkg::*;

    logic       w_q_push;
    t_lane_word w_q_in;
    t_lane_word w_q_out;
    logic       w_q_pop;
    logic       w_q_empty;

    // Front: count lane positions and mark the last lane of each state
    kfp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_lane_in (i_lane_in),
        .i_q_full  (full),
        .o_q_push  (w_q_push),
        .o_q_word  (w_q_in)
    );

    // Short queue: lets the front accept while the back is busy
    kfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_word  (w_q_in),
        .i_pop   (w_q_pop),
        .o_word  (w_q_out),
        .o_full  (full),
        .o_empty (w_q_empty)
    );

    // Back: load the lane store, run the rounds, emit through the output register
    kfp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_word      (w_q_out),
        .i_q_empty     (w_q_empty),
        .o_q_pop       (w_q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_lane_out    (o_lane_out),
        .o_lane_number (o_lane_number),
        .o_final_lane  (o_final_lane)
    );

    // Final flag marks exactly the last lane position
    `KFP_ASSERT_SAME(a_final_is_last, i_clk, i_rst_n, !empty, o_final_lane == (o_lane_number == LANE_LAST), "final flag does not match lane number")
    // After the last lane leaves, nothing is ready until a new state has loaded
    `KFP_ASSERT_NEXT(a_gap_after_final, i_clk, i_rst_n, !empty && pop && o_final_lane, empty, "result shown straight after final lane")
    // Lane numbers of one state come out in rising order
    `KFP_ASSERT_NEXT(a_lane_order, i_clk, i_rst_n, !empty && pop && !o_final_lane, empty || (o_lane_number == $past(o_lane_number) + 5'd1), "lane number out of order")

endmodule
